// ----- sv/key_short_long_press_classifier_core_macros.svh -----
// Assertion macros shared by the press classifier RTL.
`ifndef KEY_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define KEY_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kslp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kslp: next-cycle check failed");

`endif

// ----- sv/kslp_pkg.sv -----
// Types and constants of the key short/long press classifier.
`timescale 1ns / 1ps

package kslp_pkg;

    // Width of the key fields carried by one scan item and one result item.
    localparam int KEYS_W     = 2;
    localparam int TICK_W     = 32;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR  = 8'd1;

    localparam logic [TICK_W-1:0] SHORT_THR_RST = 32'd2;
    localparam logic [TICK_W-1:0] LONG_THR_RST  = 32'd300;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_LONG = 2'd2
    } t_phase;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } t_lane_ev;

    typedef struct packed {
        logic [KEYS_W-1:0] short_mask;
        logic [KEYS_W-1:0] long_mask;
    } t_result;

endpackage

// ----- sv/kslp_if.sv -----
// Handshake interfaces for the scan, result and configuration channels.
`timescale 1ns / 1ps

interface kslp_scan_if;
    import kslp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KEYS_W-1:0] pressed_levels;
    logic [TICK_W-1:0] now_ticks;
    modport source (output valid, output pressed_levels, output now_ticks, input ready);
    modport sink   (input valid, input pressed_levels, input now_ticks, output ready);
endinterface

interface kslp_result_if;
    import kslp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KEYS_W-1:0] short_press_mask;
    logic [KEYS_W-1:0] long_press_mask;
    modport source (output valid, output short_press_mask, output long_press_mask,
                    input ready);
    modport sink   (input valid, input short_press_mask, input long_press_mask,
                    output ready);
endinterface

interface kslp_cfg_if;
    import kslp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/kslp_lane.sv -----
// One key lane: phase and press timestamp tracking with event detection.
`timescale 1ns / 1ps

module kslp_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_pressed,
    input  logic [kslp_pkg::TICK_W-1:0] i_now,
    input  logic [kslp_pkg::TICK_W-1:0] i_short_thr,
    input  logic [kslp_pkg::TICK_W-1:0] i_long_thr,
    output kslp_pkg::t_lane_ev       o_ev
);
    import kslp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_start, n_start;
    logic [TICK_W-1:0] held;
    t_lane_ev          ev;

    // Held time wraps modulo 2^32 by plain unsigned subtraction.
    assign held = i_now - r_start;

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        ev      = '0;
        unique case (r_phase)
            PH_DOWN: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                    n_start = '0;
                    if (held >= i_short_thr && held < i_long_thr) begin
                        ev.short_ev = 1'b1;
                    end else if (held >= i_long_thr) begin
                        ev.long_ev = 1'b1;
                    end
                end else if (held >= i_long_thr) begin
                    n_start    = i_now;
                    n_phase    = PH_LONG;
                    ev.long_ev = 1'b1;
                end
            end
            PH_LONG: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                    n_start = '0;
                end else if (held >= i_long_thr) begin
                    n_start    = i_now;
                    ev.long_ev = 1'b1;
                end
            end
            default: begin
                // A fresh press has held time zero, so it is long at once only
                // when the long threshold is zero.
                if (i_pressed) begin
                    n_start = i_now;
                    n_phase = PH_DOWN;
                    if (i_long_thr == '0) begin
                        n_phase    = PH_LONG;
                        ev.long_ev = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_start <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_start <= n_start;
        end
    end

    assign o_ev = ev;

endmodule

// ----- sv/kslp_merge.sv -----
// Merges the per-lane events into the short and long press masks of one result.
`timescale 1ns / 1ps

module kslp_merge #(
    parameter int NUM_KEYS = 2
) (
    input  kslp_pkg::t_lane_ev i_ev [NUM_KEYS],
    output kslp_pkg::t_result  o_result
);
    import kslp_pkg::*;

    // Keys beyond the field width are dropped; missing keys read as no event.
    for (genvar k = 0; k < KEYS_W; k++) begin : g_bit
        if (k < NUM_KEYS) begin : g_lane
            assign o_result.short_mask[k] = i_ev[k].short_ev;
            assign o_result.long_mask[k]  = i_ev[k].long_ev;
        end else begin : g_none
            assign o_result.short_mask[k] = 1'b0;
            assign o_result.long_mask[k]  = 1'b0;
        end
    end

endmodule

// ----- sv/key_short_long_press_classifier_core.sv -----
// A result item enters the two-entry result buffer when its scan is accepted and is
// offered once older results are taken. Throughput: one scan item per cycle unless
// the buffer is full; each key has its own lane, so scans flow while one result waits.
// Reset (synchronous, active low): all keys idle with zero timestamps,
// thresholds back to 2 and 300 ticks, result buffer emptied.
`timescale 1ns / 1ps
`include "key_short_long_press_classifier_core_macros.svh"

module key_short_long_press_classifier_core #(
    parameter int NUM_KEYS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kslp_scan_if.sink     i_scan,
    kslp_cfg_if.sink      i_cfg,
    kslp_result_if.source o_result
);
    import kslp_pkg::*;

    logic [TICK_W-1:0] r_short_thr;
    logic [TICK_W-1:0] r_long_thr;

    t_lane_ev w_ev [NUM_KEYS];
    t_result  w_res;

    t_result  r_buf [2];
    logic     r_head;
    logic [1:0] r_cnt, n_cnt;
    logic     push, pop, tail;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr <= SHORT_THR_RST;
            r_long_thr  <= LONG_THR_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_SHORT_THR) begin
                r_short_thr <= i_cfg.data;
            end else if (i_cfg.index == REG_LONG_THR) begin
                r_long_thr <= i_cfg.data;
            end
        end
    end

    assign i_scan.ready = (r_cnt != 2'd2);
    assign push = i_scan.valid && i_scan.ready;
    assign pop  = o_result.valid && o_result.ready;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic pressed;
        if (k < KEYS_W) begin : g_in
            assign pressed = i_scan.pressed_levels[k];
        end else begin : g_off
            assign pressed = 1'b0;
        end
        kslp_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (push),
            .i_pressed   (pressed),
            .i_now       (i_scan.now_ticks),
            .i_short_thr (r_short_thr),
            .i_long_thr  (r_long_thr),
            .o_ev        (w_ev[k])
        );
    end

    kslp_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
        .i_ev     (w_ev),
        .o_result (w_res)
    );

    assign tail = r_head ^ r_cnt[0];

    always_comb begin
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (pop) begin
                r_head <= ~r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[tail] <= w_res;
        end
    end

    assign o_result.valid            = (r_cnt != 2'd0);
    assign o_result.short_press_mask = r_buf[r_head].short_mask;
    assign o_result.long_press_mask  = r_buf[r_head].long_mask;

    `KSLP_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `KSLP_ASSERT_NEXT(a_push_only, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + 2'd1)
    `KSLP_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && !push, r_cnt == $past(r_cnt) - 2'd1)

endmodule
